/* sv/deadline_timer_table_assert.svh */
// Assertion macros for the deadline timer table.
// Included by the top level; no other dependencies.
`ifndef DEADLINE_TIMER_TABLE_ASSERT_SVH
`define DEADLINE_TIMER_TABLE_ASSERT_SVH
`ifndef SYNTH
`define DTT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define DTT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DTT_ASSERT_IMP(lbl, ante, cons)
`define DTT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* sv/dtt_pkg.sv */
// Shared codes and types of the deadline timer table.
// No dependencies.
package dtt_pkg;
  localparam logic [2:0] FN_ADD     = 3'd0;
  localparam logic [2:0] FN_CANCEL  = 3'd1;
  localparam logic [2:0] FN_REFRESH = 3'd2;
  localparam logic [2:0] FN_RESET   = 3'd3;
  localparam logic [2:0] FN_COLLECT = 3'd4;
  localparam logic [2:0] FN_QUERY   = 3'd5;

  localparam logic [1:0] MD_FREE = 2'd0;
  localparam logic [1:0] MD_ACT  = 2'd1;
  localparam logic [1:0] MD_DUE  = 2'd2;

  localparam int MAX_OUT = 16;

  typedef struct packed {
    logic [1:0] mode;
    logic       set_act;
    logic       clr_act;
    logic       dl_we;
    logic       per_we;
    logic       rec_we;
    logic       set_taken;
    logic       clr_taken;
  } dtt_ctl_t;
endpackage

/* sv/deadline_timer_table.sv */
// Deadline timer table: a row of slot cells with a sequencing controller.
// Each search passes along the cells. Add searches for a free slot, then, if one is found,
// for the front; query and a reset that rewrites an active slot search once; collect
// searches once per result and once more; cancel, refresh and other resets do not search.
// One request at a time. rst_n synchronous: all slots inactive, no notification pending.
// Depends on dtt_pkg, dtt_cell and deadline_timer_table_assert.svh.
`include "deadline_timer_table_assert.svh"
module deadline_timer_table #(
  parameter int TIMER_SLOTS = 16,
  parameter int TIME_BITS   = 48
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // func[2:0], slot_sel[6:3], new_period[38:7], repeat_mode[39],
  // restart_now[40], now_time[88:41], zero fill
  input  logic [95:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // ok[0], slot_out[4:1], wait_time[52:5], table_empty[53],
  // front_notify[54], zero fill
  output logic [55:0] out_tdata,
  output logic        out_tlast
);
  import dtt_pkg::*;

  localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int IW     = (SLOT_W > 4) ? SLOT_W : 4;
  localparam int W2     = (TIME_BITS > 48) ? TIME_BITS : 48;
  localparam int SW     = TIME_BITS + 33;
  localparam int CW     = SLOT_W + 1;
  localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DISP  = 4'd1;
  localparam logic [3:0] ST_SCAN  = 4'd2;
  localparam logic [3:0] ST_ADDW  = 4'd3;
  localparam logic [3:0] ST_RS1   = 4'd4;
  localparam logic [3:0] ST_RS2   = 4'd5;
  localparam logic [3:0] ST_COLW  = 4'd6;
  localparam logic [3:0] ST_EMIT  = 4'd7;
  localparam logic [3:0] ST_EMITC = 4'd8;

  logic [3:0]           state_r, state_nxt;
  logic [2:0]           func_r;
  logic [3:0]           sel_r;
  logic [31:0]          per_r;
  logic                 rep_r, rn_r;
  logic [TIME_BITS-1:0] now_r;
  logic [1:0]           mode_r, mode_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 phase_r, phase_nxt;
  logic [SLOT_W-1:0]    widx_r, widx_nxt;
  logic [TIME_BITS-1:0] start_r, start_nxt;
  logic                 pend_r, pend_nxt;
  logic                 ok_r, ok_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [TIME_BITS-1:0] wait_r, wait_nxt;
  logic                 nf_r, nf_nxt;
  logic [4:0]           n_r, n_nxt, k_r, k_nxt;
  logic [SLOT_W-1:0]    order_r [MAX_OUT];
  logic                 out_valid_r, out_valid_nxt;
  logic [55:0]          out_data_r, out_data_nxt;
  logic                 out_last_r, out_last_nxt;

  dtt_ctl_t             ctl;
  logic [TIMER_SLOTS-1:0] cell_act;
  logic [TIME_BITS-1:0] cell_dl  [TIMER_SLOTS];
  logic [31:0]          cell_per [TIMER_SLOTS];
  logic                 cell_rec [TIMER_SLOTS];
  logic                 lk_valid [TIMER_SLOTS+1];
  logic [TIME_BITS-1:0] lk_dl    [TIMER_SLOTS+1];
  logic [SLOT_W-1:0]    lk_idx   [TIMER_SLOTS+1];

  logic [IW-1:0]        sel_w;
  logic                 selok;
  logic [SLOT_W-1:0]    sel_idx, rd_idx, wr_idx;
  logic [TIME_BITS-1:0] rd_dl, add_a, sat_dl, end_dl;
  logic [31:0]          rd_per, add_b;
  logic                 rd_act, rd_rec, end_valid, out_free, tbl_empty;
  logic [SLOT_W-1:0]    end_idx;
  logic [SW-1:0]        sum, dw, pw;
  logic [W2-1:0]        now_wide, wait_wide;
  logic [IW-1:0]        slot_wide;
  logic                 emit_ok, emit_nf, emit_last;
  logic [SLOT_W-1:0]    emit_slot;
  logic [TIME_BITS-1:0] emit_wait;

  assign lk_valid[0] = 1'b0;
  assign lk_dl[0]    = '0;
  assign lk_idx[0]   = '0;

  for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
    dtt_cell #(.TIME_BITS(TIME_BITS), .SLOT_W(SLOT_W), .IDX(g)) u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl), .wr_idx(wr_idx), .wr_dl(sat_dl),
      .wr_per(per_r), .wr_rec(rep_r), .now(now_r),
      .li_valid(lk_valid[g]), .li_dl(lk_dl[g]), .li_idx(lk_idx[g]),
      .lo_valid(lk_valid[g+1]), .lo_dl(lk_dl[g+1]), .lo_idx(lk_idx[g+1]),
      .st_act(cell_act[g]), .st_dl(cell_dl[g]), .st_per(cell_per[g]),
      .st_rec(cell_rec[g])
    );
  end

  assign end_valid = lk_valid[TIMER_SLOTS];
  assign end_dl    = lk_dl[TIMER_SLOTS];
  assign end_idx   = lk_idx[TIMER_SLOTS];

  assign sel_w   = IW'(sel_r);
  assign selok   = ({28'd0, sel_r} < 32'(TIMER_SLOTS));
  assign sel_idx = sel_w[SLOT_W-1:0];
  assign rd_idx  = (state_r == ST_COLW) ? widx_r : sel_idx;
  assign wr_idx  = ((state_r == ST_ADDW) || (state_r == ST_COLW)) ? widx_r : sel_idx;
  assign rd_dl   = cell_dl[rd_idx];
  assign rd_per  = cell_per[rd_idx];
  assign rd_act  = cell_act[rd_idx];
  assign rd_rec  = cell_rec[rd_idx];
  assign tbl_empty = ~|cell_act;
  assign out_free  = !out_valid_r || out_tready;

  assign add_a  = (state_r == ST_RS2) ? start_r : now_r;
  assign add_b  = ((state_r == ST_COLW) || (func_r == FN_REFRESH)) ? rd_per : per_r;
  assign sum    = SW'(add_a) + SW'(add_b);
  assign sat_dl = (|sum[SW-1:TIME_BITS]) ? TMAX : sum[TIME_BITS-1:0];
  assign dw     = SW'(rd_dl);
  assign pw     = SW'(rd_per);

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    cnt_nxt   = cnt_r;
    phase_nxt = phase_r;
    widx_nxt  = widx_r;
    start_nxt = start_r;
    pend_nxt  = pend_r;
    ok_nxt    = ok_r;
    slot_nxt  = slot_r;
    wait_nxt  = wait_r;
    nf_nxt    = nf_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    ctl       = '0;
    emit_ok   = ok_r;
    emit_slot = slot_r;
    emit_wait = wait_r;
    emit_nf   = nf_r;
    emit_last = 1'b1;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_DISP;
        end
      end
      ST_DISP: begin
        ok_nxt   = 1'b0;
        slot_nxt = '0;
        wait_nxt = '0;
        nf_nxt   = 1'b0;
        cnt_nxt  = '0;
        widx_nxt = sel_idx;
        state_nxt = ST_EMIT;
        case (func_r)
          FN_ADD: begin
            mode_nxt  = MD_FREE;
            phase_nxt = 1'b0;
            state_nxt = ST_SCAN;
          end
          FN_CANCEL: begin
            ok_nxt      = selok && rd_act;
            ctl.clr_act = selok && rd_act;
          end
          FN_REFRESH: begin
            ok_nxt    = selok && rd_act;
            ctl.dl_we = selok && rd_act;
          end
          FN_RESET: begin
            if (selok && (rd_per == per_r) && !rn_r) begin
              ok_nxt = 1'b1;
            end else if (selok && rd_act) begin
              state_nxt = ST_RS1;
            end
          end
          FN_COLLECT: begin
            ctl.clr_taken = 1'b1;
            n_nxt     = '0;
            mode_nxt  = MD_DUE;
            state_nxt = ST_SCAN;
          end
          FN_QUERY: begin
            mode_nxt  = MD_ACT;
            state_nxt = ST_SCAN;
          end
          default: begin
            ok_nxt = 1'b0;
          end
        endcase
      end
      ST_RS1: begin
        if (rn_r) begin
          start_nxt = now_r;
        end else if (dw >= pw) begin
          start_nxt = TIME_BITS'(dw - pw);
        end else begin
          start_nxt = '0;
        end
        state_nxt = ST_RS2;
      end
      ST_RS2: begin
        ctl.per_we = 1'b1;
        ctl.dl_we  = 1'b1;
        mode_nxt   = MD_ACT;
        phase_nxt  = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = ST_SCAN;
      end
      ST_ADDW: begin
        ctl.set_act = 1'b1;
        ctl.per_we  = 1'b1;
        ctl.rec_we  = 1'b1;
        ctl.dl_we   = 1'b1;
        mode_nxt    = MD_ACT;
        phase_nxt   = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = ST_SCAN;
      end
      ST_COLW: begin
        ctl.set_taken = 1'b1;
        ctl.dl_we     = rd_rec;
        ctl.clr_act   = !rd_rec;
        n_nxt         = n_r + 5'd1;
        cnt_nxt       = '0;
        state_nxt     = ST_SCAN;
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(TIMER_SLOTS)) begin
          state_nxt = ST_EMIT;
          case (func_r)
            FN_ADD, FN_RESET: begin
              if ((func_r == FN_ADD) && !phase_r) begin
                if (end_valid) begin
                  widx_nxt  = end_idx;
                  state_nxt = ST_ADDW;
                end
              end else begin
                ok_nxt   = 1'b1;
                slot_nxt = (func_r == FN_ADD) ? widx_r : '0;
                if (!pend_r && end_valid && (end_idx == widx_r)) begin
                  nf_nxt   = 1'b1;
                  pend_nxt = 1'b1;
                end
              end
            end
            FN_QUERY: begin
              ok_nxt = 1'b1;
              if (!end_valid) begin
                wait_nxt = TMAX;
              end else begin
                pend_nxt = 1'b0;
                wait_nxt = (end_dl > now_r) ? end_dl - now_r : '0;
              end
            end
            FN_COLLECT: begin
              if (end_valid && (n_r < 5'(MAX_OUT))) begin
                widx_nxt  = end_idx;
                state_nxt = ST_COLW;
              end else if (n_r != 5'd0) begin
                k_nxt     = '0;
                state_nxt = ST_EMITC;
              end
            end
            default: begin
              ok_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_EMITC: begin
        emit_ok   = 1'b1;
        emit_slot = order_r[k_r[3:0]];
        emit_wait = '0;
        emit_nf   = 1'b0;
        emit_last = (k_r + 5'd1 == n_r);
        if (out_free) begin
          out_valid_nxt = 1'b1;
          k_nxt         = k_r + 5'd1;
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if ((state_r == ST_EMIT || state_r == ST_EMITC) && out_free) begin
      out_data_nxt = {1'b0, emit_nf, tbl_empty, wait_wide[47:0], slot_wide[3:0], emit_ok};
      out_last_nxt = emit_last;
    end
    ctl.mode = mode_r;
  end

  assign wait_wide = W2'(emit_wait);
  assign slot_wide = IW'(emit_slot);
  assign now_wide  = W2'(in_tdata[88:41]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      n_r         <= '0;
      k_r         <= '0;
      mode_r      <= MD_ACT;
      phase_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      n_r         <= n_nxt;
      k_r         <= k_nxt;
      mode_r      <= mode_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      func_r <= in_tdata[2:0];
      sel_r  <= in_tdata[6:3];
      per_r  <= in_tdata[38:7];
      rep_r  <= in_tdata[39];
      rn_r   <= in_tdata[40];
      now_r  <= now_wide[TIME_BITS-1:0];
    end
    if (state_r == ST_COLW) begin
      order_r[n_r[3:0]] <= widx_r;
    end
    widx_r     <= widx_nxt;
    start_r    <= start_nxt;
    ok_r       <= ok_nxt;
    slot_r     <= slot_nxt;
    wait_r     <= wait_nxt;
    nf_r       <= nf_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `DTT_ASSERT_NXT(a_accept_busy, in_tvalid && in_tready, state_r == ST_DISP)
  `DTT_ASSERT_IMP(a_count_bound, 1'b1, n_r <= 5'(MAX_OUT))
  `DTT_ASSERT_IMP(a_emitc_nonempty, state_r == ST_EMITC, k_r < n_r)
endmodule

/* sv/dtt_cell.sv */
// One timer slot: its state and one stage of the earliest-entry search chain.
// Depends on dtt_pkg.
module dtt_cell #(
  parameter int TIME_BITS = 48,
  parameter int SLOT_W    = 4,
  parameter int IDX       = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dtt_pkg::dtt_ctl_t    ctl,
  input  logic [SLOT_W-1:0]    wr_idx,
  input  logic [TIME_BITS-1:0] wr_dl,
  input  logic [31:0]          wr_per,
  input  logic                 wr_rec,
  input  logic [TIME_BITS-1:0] now,
  input  logic                 li_valid,
  input  logic [TIME_BITS-1:0] li_dl,
  input  logic [SLOT_W-1:0]    li_idx,
  output logic                 lo_valid,
  output logic [TIME_BITS-1:0] lo_dl,
  output logic [SLOT_W-1:0]    lo_idx,
  output logic                 st_act,
  output logic [TIME_BITS-1:0] st_dl,
  output logic [31:0]          st_per,
  output logic                 st_rec
);
  import dtt_pkg::*;

  logic                 act_r, taken_r, rec_r, lv_r;
  logic [TIME_BITS-1:0] dl_r, ld_r;
  logic [31:0]          per_r;
  logic [SLOT_W-1:0]    li_r;
  logic                 hit, elig, take;

  assign hit = (wr_idx == SLOT_W'(IDX));

  always_comb begin
    case (ctl.mode)
      MD_FREE: elig = !act_r;
      MD_ACT:  elig = act_r;
      MD_DUE:  elig = act_r && !taken_r && (dl_r <= now);
      default: elig = 1'b0;
    endcase
    take = elig && (!li_valid || ((ctl.mode != MD_FREE) && (dl_r < li_dl)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r   <= 1'b0;
      taken_r <= 1'b0;
      lv_r    <= 1'b0;
    end else begin
      lv_r <= take ? 1'b1 : li_valid;
      if (hit && ctl.set_act) begin
        act_r <= 1'b1;
      end else if (hit && ctl.clr_act) begin
        act_r <= 1'b0;
      end
      if (ctl.clr_taken) begin
        taken_r <= 1'b0;
      end else if (hit && ctl.set_taken) begin
        taken_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    ld_r <= take ? dl_r : li_dl;
    li_r <= take ? SLOT_W'(IDX) : li_idx;
    if (hit && ctl.dl_we) begin
      dl_r <= wr_dl;
    end
    if (hit && ctl.per_we) begin
      per_r <= wr_per;
    end
    if (hit && ctl.rec_we) begin
      rec_r <= wr_rec;
    end
  end

  assign lo_valid = lv_r;
  assign lo_dl    = ld_r;
  assign lo_idx   = li_r;
  assign st_act   = act_r;
  assign st_dl    = dl_r;
  assign st_per   = per_r;
  assign st_rec   = rec_r;
endmodule

/* test/tb.sv */
// Self-checking bench for deadline_timer_table: random and directed timer requests,
// results checked against a behavioral timer table kept in the bench.
// Depends on dtt_pkg and the deadline_timer_table RTL.
module tb;
  import dtt_pkg::*;

  localparam int SLOTS = 16;
  localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;
  localparam int WDOG = 20000;

  typedef struct packed {
    logic [2:0] func;
    logic [3:0] sel;
    logic [31:0] per;
    logic rep;
    logic rn;
    logic [47:0] now;
  } req_t;

  typedef struct packed {
    logic ok;
    logic [3:0] slot;
    logic [47:0] wait_t;
    logic empty;
    logic nf;
    logic last;
  } res_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [95:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [55:0] out_tdata;
  logic out_tlast;

  deadline_timer_table DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always #5 clk = ~clk;

  logic [47:0] tm_deadline [SLOTS];
  logic [31:0] tm_period [SLOTS];
  logic tm_recurs [SLOTS];
  logic tm_active [SLOTS];
  logic tm_pending;
  logic ever_written [SLOTS];

  req_t pending_reqs[$];
  res_t expected_results[$];
  int errors = 0;
  int n_sent = 0;
  int n_got = 0;
  int n_collected = 0;
  bit no_idle = 0;
  bit hold_send = 0;
  bit done_feed = 0;
  bit in_taken = 0;
  int idle_cnt = 0;
  logic [47:0] clock_ms = 48'd1000;

  function automatic logic [47:0] sat_sum(logic [47:0] a, logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + b;
    return s[48] ? TMAX : s[47:0];
  endfunction

  function automatic bit is_earlier(int a, int b);
    return tm_deadline[a] < tm_deadline[b] ||
           (tm_deadline[a] == tm_deadline[b] && a < b);
  endfunction

  function automatic bit table_idle();
    foreach (tm_active[i]) if (tm_active[i]) return 0;
    return 1;
  endfunction

  function automatic bit claim_front(int s);
    for (int i = 0; i < SLOTS; i++)
      if (tm_active[i] && i != s && is_earlier(i, s)) return 0;
    if (tm_pending) return 0;
    tm_pending = 1;
    return 1;
  endfunction

  function automatic void push_res(bit ok, int slot, logic [47:0] w, bit nf, bit lst);
    res_t r;
    r.ok = ok;
    r.slot = slot[3:0];
    r.wait_t = w;
    r.empty = table_idle();
    r.nf = nf;
    r.last = lst;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_timers(req_t q);
    int i, n, best;
    bit nf, ok;
    bit taken [SLOTS];
    int order [16];
    logic [47:0] start;
    case (q.func)
      FN_ADD: begin
        for (i = 0; i < SLOTS; i++) if (!tm_active[i]) break;
        if (i == SLOTS) begin
          push_res(0, 0, 0, 0, 1);
        end else begin
          tm_period[i] = q.per;
          tm_recurs[i] = q.rep;
          tm_deadline[i] = sat_sum(q.now, q.per);
          tm_active[i] = 1;
          ever_written[i] = 1;
          nf = claim_front(i);
          push_res(1, i, 0, nf, 1);
        end
      end
      FN_CANCEL: begin
        ok = tm_active[q.sel];
        if (ok) tm_active[q.sel] = 0;
        push_res(ok, 0, 0, 0, 1);
      end
      FN_REFRESH: begin
        ok = tm_active[q.sel];
        if (ok) tm_deadline[q.sel] = sat_sum(q.now, tm_period[q.sel]);
        push_res(ok, 0, 0, 0, 1);
      end
      FN_RESET: begin
        ok = 0;
        nf = 0;
        if (tm_period[q.sel] == q.per && !q.rn) begin
          ok = 1;
        end else if (tm_active[q.sel]) begin
          if (q.rn) start = q.now;
          else if (tm_deadline[q.sel] >= tm_period[q.sel])
            start = tm_deadline[q.sel] - tm_period[q.sel];
          else start = 0;
          tm_period[q.sel] = q.per;
          tm_deadline[q.sel] = sat_sum(start, q.per);
          ok = 1;
          nf = claim_front(q.sel);
        end
        push_res(ok, 0, 0, nf, 1);
      end
      FN_COLLECT: begin
        n = 0;
        foreach (taken[k]) taken[k] = 0;
        while (n < 16) begin
          best = SLOTS;
          for (i = 0; i < SLOTS; i++) begin
            if (!tm_active[i] || taken[i] || tm_deadline[i] > q.now) continue;
            if (best == SLOTS || is_earlier(i, best)) best = i;
          end
          if (best == SLOTS) break;
          taken[best] = 1;
          order[n++] = best;
        end
        for (i = 0; i < n; i++)
          if (tm_recurs[order[i]])
            tm_deadline[order[i]] = sat_sum(q.now, tm_period[order[i]]);
          else tm_active[order[i]] = 0;
        if (n == 0) push_res(0, 0, 0, 0, 1);
        for (i = 0; i < n; i++) push_res(1, order[i], 0, 0, i == n - 1);
        n_collected += n;
      end
      FN_QUERY: begin
        best = SLOTS;
        for (i = 0; i < SLOTS; i++)
          if (tm_active[i] && (best == SLOTS || is_earlier(i, best))) best = i;
        if (best == SLOTS) begin
          push_res(1, 0, TMAX, 0, 1);
        end else begin
          tm_pending = 0;
          push_res(1, 0, tm_deadline[best] > q.now ? tm_deadline[best] - q.now : 48'd0,
                   0, 1);
        end
      end
      default: push_res(0, 0, 0, 0, 1);
    endcase
  endfunction

  // Reset is kept off slots never written, so its period compare stays defined.
  function automatic req_t mk_req(logic [2:0] f, int sel, logic [31:0] per, bit rep,
                                  bit rn, logic [47:0] now);
    req_t q;
    q.func = f;
    q.sel = sel[3:0];
    q.per = per;
    q.rep = rep;
    q.rn = rn;
    q.now = now;
    return q;
  endfunction

  function automatic logic [31:0] rnd_period();
    case ($urandom_range(0, 9))
      0: return 32'hFFFF_FFFF;
      1: return 0;
      2: return $urandom;
      default: return $urandom_range(1, 400);
    endcase
  endfunction

  function automatic logic [47:0] rnd_now();
    if ($urandom_range(0, 19) == 0) return 48'({$urandom, $urandom});
    if ($urandom_range(0, 29) == 0) return TMAX;
    clock_ms = clock_ms + $urandom_range(0, 120);
    return clock_ms;
  endfunction

  function automatic bit written_any();
    foreach (ever_written[i]) if (ever_written[i]) return 1;
    return 0;
  endfunction

  function automatic req_t rnd_req();
    int s;
    logic [2:0] f;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) f = FN_ADD;
    else if (pick < 35) f = FN_CANCEL;
    else if (pick < 45) f = FN_REFRESH;
    else if (pick < 60) f = FN_RESET;
    else if (pick < 82) f = FN_COLLECT;
    else if (pick < 97) f = FN_QUERY;
    else f = 3'($urandom_range(6, 7));
    s = $urandom_range(0, 15);
    if (f == FN_RESET) begin
      if (!written_any()) f = FN_QUERY;
      else while (!ever_written[s]) s = $urandom_range(0, 15);
    end
    if (f == FN_RESET && $urandom_range(0, 3) == 0)
      return mk_req(f, s, tm_period[s], 1'($urandom), 0, rnd_now());
    return mk_req(f, s, rnd_period(), 1'($urandom), 1'($urandom), rnd_now());
  endfunction

  // Queue requests through the predictor so generation sees the state in order.
  task automatic queue_req(req_t q);
    predict_timers(q);
    pending_reqs.push_back(q);
  endtask

  always @(negedge clk) begin
    if (rst_n) begin
      out_tready <= no_idle || ($urandom_range(0, 99) >= 31);
    end
  end

  logic accepted;
  always @(posedge clk) begin
    accepted = 0;
    in_taken = rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      accepted = 1;
      n_sent++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      res_t a, e;
      accepted = 1;
      n_got++;
      a = {out_tdata[0], out_tdata[4:1], out_tdata[52:5], out_tdata[53], out_tdata[54],
           out_tlast};
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: %h", a);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (a.ok !== e.ok) begin $error("ok exp %0d got %0d", e.ok, a.ok); errors++; end
        if (a.slot !== e.slot) begin
          $error("slot_out exp %0d got %0d", e.slot, a.slot); errors++;
        end
        if (a.wait_t !== e.wait_t) begin
          $error("wait_time exp %0d got %0d", e.wait_t, a.wait_t); errors++;
        end
        if (a.empty !== e.empty) begin
          $error("table_empty exp %0d got %0d", e.empty, a.empty); errors++;
        end
        if (a.nf !== e.nf) begin
          $error("front_notify exp %0d got %0d", e.nf, a.nf); errors++;
        end
        if (a.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, a.last); errors++;
        end
      end
    end
    idle_cnt = accepted ? 0 : idle_cnt + 1;
  end

  // Driver: hold valid until accepted, then advance to the next pending request.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && !in_taken) begin
      end else if (!hold_send && pending_reqs.size() > 0 &&
                   (no_idle || $urandom_range(0, 99) >= 31)) begin
        req_t q;
        q = pending_reqs.pop_front();
        in_tdata <= {7'd0, q.now, q.rn, q.rep, q.per, q.sel, q.func};
        in_tvalid <= 1;
      end else begin
        in_tvalid <= 0;
      end
    end
  end

  initial begin
    foreach (tm_active[i]) begin
      tm_active[i] = 0; tm_deadline[i] = 0; tm_period[i] = 0; tm_recurs[i] = 0;
      ever_written[i] = 0;
    end
    tm_pending = 0;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1;

    // Directed: empty query, unused codes, misses on empty table, extremes.
    queue_req(mk_req(FN_QUERY, 0, 0, 0, 0, 0));
    queue_req(mk_req(3'd6, 15, 0, 1, 1, TMAX));
    queue_req(mk_req(3'd7, 0, 0, 0, 0, 0));
    queue_req(mk_req(FN_CANCEL, 3, 0, 0, 0, 5));
    queue_req(mk_req(FN_REFRESH, 15, 0, 0, 0, 5));
    queue_req(mk_req(FN_COLLECT, 0, 0, 0, 0, 10));
    queue_req(mk_req(FN_ADD, 0, 32'hFFFF_FFFF, 1, 0, TMAX - 5));
    queue_req(mk_req(FN_ADD, 0, 0, 0, 1, 100));
    queue_req(mk_req(FN_ADD, 0, 50, 1, 0, 100));
    queue_req(mk_req(FN_RESET, 2, 50, 0, 0, 110));
    queue_req(mk_req(FN_RESET, 2, 30, 0, 0, 110));
    queue_req(mk_req(FN_RESET, 2, 70, 1, 1, 120));
    queue_req(mk_req(FN_RESET, 1, 20, 0, 0, 120));
    queue_req(mk_req(FN_QUERY, 0, 0, 0, 0, 120));
    queue_req(mk_req(FN_QUERY, 0, 0, 0, 0, 200));
    queue_req(mk_req(FN_REFRESH, 2, 0, 0, 0, 130));
    for (int i = 3; i < 17; i++) queue_req(mk_req(FN_ADD, 0, 32'(i), 1'(i & 1), 0, 150));
    queue_req(mk_req(FN_COLLECT, 0, 0, 0, 0, TMAX));
    queue_req(mk_req(FN_CANCEL, 0, 0, 0, 0, 160));
    wait (pending_reqs.size() == 0 && expected_results.size() == 0);

    // Random: an unbroken stretch first, then a pause to drain, then the rest.
    no_idle = 1;
    for (int i = 0; i < 60; i++) queue_req(rnd_req());
    wait (pending_reqs.size() == 0);
    no_idle = 0;
    hold_send = 1;
    wait (expected_results.size() == 0);
    hold_send = 0;
    for (int i = 0; i < 240; i++) queue_req(rnd_req());
    done_feed = 1;
  end

  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (idle_cnt >= WDOG) begin
        $display("tb: errors");
        $finish;
      end
      if (done_feed && pending_reqs.size() == 0 && !in_tvalid &&
          expected_results.size() == 0) begin
        repeat (200) @(posedge clk);
        $display("requests %0d, results %0d, expired slots collected %0d",
                 n_sent, n_got, n_collected);
        if (errors == 0 && expected_results.size() == 0) $display("tb: clean");
        else $display("tb: errors");
        $finish;
      end
    end
  end
endmodule

/* filelist.f */
+incdir+sv
sv/dtt_pkg.sv
sv/dtt_cell.sv
sv/deadline_timer_table.sv
test/tb.sv
